FILE: rtl/blg_pkg.sv
// battery level gauge package: payload structs, microcode word, control codes,
// voltage profile table and microprogram. no dependencies.
package blg_pkg;

  localparam int MV_W       = 12;
  localparam int AVG_W      = 13;
  localparam int SUM_W      = 20;
  localparam int IDX_W      = 7;
  localparam int PCT_W      = 7;
  localparam int ROM_LEN    = 101;
  localparam int ROM_IDX_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PERIOD_W   = 16;
  localparam int MARGIN_W   = 10;
  localparam int PC_W       = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd100;

  typedef struct packed {
    logic            func;
    logic [31:0]     time_ms;
    logic [MV_W-1:0] sample_mv;
  } in_t;

  typedef struct packed {
    logic [PCT_W-1:0] percentage;
    logic             charging;
    logic             measure_due;
    logic             level_done;
  } out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFRESH_PERIOD = 1'b0,
    REG_CHARGE_MARGIN  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_UPDATE,
    OP_DIV,
    OP_SEARCH,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_ACCEPT,
    C_NO_COMPLETE,
    C_SRCH_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uop_t;

  typedef struct packed {
    logic accept;
    logic no_complete;
    logic srch_more;
    logic out_busy;
  } flags_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_UPDATE = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd2;
  localparam logic [PC_W-1:0] PC_SEARCH = 3'd3;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;

  // voltage profile, index is percent
  localparam logic [MV_W-1:0] SOC_ROM [ROM_LEN] = '{
    12'd3483, 12'd3484, 12'd3486, 12'd3487, 12'd3489, 12'd3491, 12'd3493, 12'd3495,
    12'd3497, 12'd3499, 12'd3502, 12'd3504, 12'd3507, 12'd3510, 12'd3513, 12'd3515,
    12'd3519, 12'd3522, 12'd3525, 12'd3528, 12'd3532, 12'd3535, 12'd3539, 12'd3542,
    12'd3546, 12'd3550, 12'd3554, 12'd3558, 12'd3562, 12'd3566, 12'd3570, 12'd3574,
    12'd3578, 12'd3583, 12'd3587, 12'd3592, 12'd3596, 12'd3601, 12'd3605, 12'd3610,
    12'd3614, 12'd3619, 12'd3624, 12'd3629, 12'd3633, 12'd3638, 12'd3643, 12'd3648,
    12'd3653, 12'd3658, 12'd3663, 12'd3668, 12'd3673, 12'd3678, 12'd3682, 12'd3687,
    12'd3692, 12'd3697, 12'd3702, 12'd3707, 12'd3712, 12'd3717, 12'd3722, 12'd3727,
    12'd3732, 12'd3737, 12'd3742, 12'd3747, 12'd3751, 12'd3756, 12'd3761, 12'd3766,
    12'd3770, 12'd3775, 12'd3779, 12'd3784, 12'd3788, 12'd3793, 12'd3797, 12'd3802,
    12'd3806, 12'd3810, 12'd3814, 12'd3818, 12'd3822, 12'd3826, 12'd3830, 12'd3834,
    12'd3838, 12'd3842, 12'd3845, 12'd3849, 12'd3852, 12'd3856, 12'd3859, 12'd3862,
    12'd3865, 12'd3868, 12'd3871, 12'd3874, 12'd3876
  };

  function automatic logic [MV_W-1:0] soc_mv(input logic [ROM_IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    v = '0;
    if (int'(idx) < ROM_LEN) begin
      v = SOC_ROM[idx];
    end
    return v;
  endfunction

  // microprogram: a taken condition jumps to target, else fall through
  // (or back to idle on the last step)
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      PC_IDLE:   u = '{op: OP_LOAD,   cond: C_NO_ACCEPT,   target: PC_IDLE,   last: 1'b0};
      PC_UPDATE: u = '{op: OP_UPDATE, cond: C_NO_COMPLETE, target: PC_EMIT,   last: 1'b0};
      PC_DIV:    u = '{op: OP_DIV,    cond: C_NEVER,       target: PC_IDLE,   last: 1'b0};
      PC_SEARCH: u = '{op: OP_SEARCH, cond: C_SRCH_MORE,   target: PC_SEARCH, last: 1'b0};
      PC_FINISH: u = '{op: OP_FINISH, cond: C_NEVER,       target: PC_IDLE,   last: 1'b0};
      PC_EMIT:   u = '{op: OP_EMIT,   cond: C_OUT_BUSY,    target: PC_EMIT,   last: 1'b1};
      default:   u = '{op: OP_LOAD,   cond: C_NEVER,       target: PC_IDLE,   last: 1'b1};
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/blg_useq.sv
// battery level gauge microsequencer: step counter, microcode rom, jumps.
// depends on blg_pkg.
module blg_useq (
  input  logic          clk,
  input  logic          rst,
  input  blg_pkg::flags_t flags,
  output blg_pkg::uop_t   uop
);
  import blg_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign uop = ucode(pc);

  always_comb begin
    case (uop.cond)
      C_NEVER:       take = 1'b0;
      C_NO_ACCEPT:   take = !flags.accept;
      C_NO_COMPLETE: take = flags.no_complete;
      C_SRCH_MORE:   take = flags.srch_more;
      C_OUT_BUSY:    take = flags.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = uop.target;
    end else if (uop.last) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: rtl/blg_dp.sv
// battery level gauge datapath: config regs, charge check, sample sum,
// reciprocal divide, profile search and output register. depends on blg_pkg.
module blg_dp #(
  parameter int SAMPLE_COUNT    = 100,
  parameter int PROFILE_ENTRIES = 101
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  blg_pkg::uop_t                        uop,
  output blg_pkg::flags_t                      flags,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  blg_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output blg_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import blg_pkg::*;

  localparam int NENT   = (PROFILE_ENTRIES > ROM_LEN) ? ROM_LEN : PROFILE_ENTRIES;
  localparam int DIV_SH = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  // rounded-up reciprocal, exact over the whole sum range
  localparam longint RECIP_L =
    ((longint'(1) << DIV_SH) + longint'(SAMPLE_COUNT) - 1) / longint'(SAMPLE_COUNT);
  localparam logic [MUL_W-1:0]     RECIP    = MUL_W'(RECIP_L);
  localparam logic [IDX_W:0]       IDX_END  = (IDX_W + 1)'(SAMPLE_COUNT);
  localparam logic [ROM_IDX_W-1:0] K_END    = ROM_IDX_W'(NENT);
  localparam logic [ROM_IDX_W-1:0] K_LAST   = ROM_IDX_W'(NENT - 1);

  // configuration and block state
  logic [PERIOD_W-1:0] refresh_period;
  logic [MARGIN_W-1:0] charge_margin;
  logic [31:0]         last_refresh;
  logic                charging_flag;
  logic [PCT_W-1:0]    level_percent;
  logic [SUM_W-1:0]    sample_sum;
  logic [IDX_W-1:0]    sample_index;
  logic                done;

  // working registers
  in_t                 item;
  logic [SUM_W-1:0]    div_sum;
  logic [AVG_W-1:0]    avg;
  logic [ROM_IDX_W-1:0] k;
  logic [AVG_W-1:0]    best;

  logic                accept;
  logic [IDX_W:0]      idx_inc;
  logic                complete;
  logic [SUM_W-1:0]    sum_inc;
  logic [MV_W-1:0]     full_mv;
  logic [AVG_W-1:0]    margin_sum;
  logic                high;
  logic [PROD_W-1:0]   prod;
  logic [AVG_W-1:0]    prof;
  logic [AVG_W-1:0]    delta;
  logic                srch_stop;
  logic [31:0]         elapsed;
  logic                due;
  logic                out_busy;
  logic                emit;

  assign in_stall  = rst || (uop.op != OP_LOAD);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = !rst;

  assign idx_inc  = {1'b0, sample_index} + 1'b1;
  assign complete = item.func && (idx_inc >= IDX_END);
  assign sum_inc  = sample_sum + {{(SUM_W - MV_W - 1){1'b0}}, item.sample_mv, 1'b0};

  // full charge is the top of the active profile
  assign full_mv    = soc_mv(K_LAST);
  assign margin_sum = {1'b0, item.sample_mv} + {{(AVG_W - MARGIN_W){1'b0}}, charge_margin};
  assign high       = margin_sum > {1'b0, full_mv};

  // divide by SAMPLE_COUNT as multiply by reciprocal and shift
  assign prod = {{MUL_W{1'b0}}, div_sum} * {{SUM_W{1'b0}}, RECIP};

  assign prof  = {1'b0, soc_mv(k)};
  assign delta = (avg > prof) ? (avg - prof) : (prof - avg);
  assign srch_stop = (k == K_END) || (best < delta);

  assign elapsed  = item.time_ms - last_refresh;
  assign due      = (elapsed >= {16'b0, refresh_period}) && !charging_flag;
  assign out_busy = out_valid && out_stall;
  assign emit     = (uop.op == OP_EMIT) && !out_busy;

  always_comb begin
    flags.accept      = accept;
    flags.no_complete = !complete;
    flags.srch_more   = !srch_stop;
    flags.out_busy    = out_busy;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= PERIOD_RESET;
      charge_margin  <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_REFRESH_PERIOD: refresh_period <= cfg_data[PERIOD_W-1:0];
        REG_CHARGE_MARGIN:  charge_margin  <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_refresh  <= '0;
      charging_flag <= 1'b0;
      level_percent <= '0;
      sample_sum    <= '0;
      sample_index  <= '0;
      done          <= 1'b0;
    end else begin
      case (uop.op)
        OP_LOAD: begin
          if (accept) begin
            done <= 1'b0;
          end
        end
        OP_UPDATE: begin
          if (!item.func) begin
            if (!charging_flag && high) begin
              charging_flag <= 1'b1;
            end else if (charging_flag && !high) begin
              // leaving charge forces a refresh
              charging_flag <= 1'b0;
              last_refresh  <= '0;
            end
          end else if (complete) begin
            sample_sum   <= '0;
            sample_index <= '0;
          end else begin
            sample_sum   <= sum_inc;
            sample_index <= idx_inc[IDX_W-1:0];
          end
        end
        OP_SEARCH: begin
          if (srch_stop) begin
            level_percent <= k - 1'b1;
          end
        end
        OP_FINISH: begin
          last_refresh <= item.time_ms;
          done         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (uop.op)
      OP_LOAD: begin
        if (accept) begin
          item <= in_data;
        end
      end
      OP_UPDATE: begin
        div_sum <= sum_inc;
        k       <= '0;
        best    <= '1;
      end
      OP_DIV: begin
        // average never exceeds twice the largest sample
        avg <= prod[DIV_SH +: AVG_W];
      end
      OP_SEARCH: begin
        if (!srch_stop) begin
          best <= delta;
          k    <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.percentage  <= level_percent;
      out_data.charging    <= charging_flag;
      out_data.measure_due <= due;
      out_data.level_done  <= done;
    end
  end

endmodule

FILE: rtl/battery_level_gauge.sv
// battery level gauge top level: microsequencer plus datapath.
// depends on blg_pkg, blg_useq and blg_dp.
//
// usage: each input beat is a poll (func 0) or a measurement sample (func 1)
// with the current millisecond time and a millivolt reading. every input beat
// gives exactly one output beat with percentage, charging, measure_due and
// level_done. the two config registers are written on the cfg channel by
// index (0 refresh period, 1 charge margin) while the block is idle.
// order of work: a poll or a non-final sample goes from accept through the
// update and emit steps back to idle. the final sample of a burst also takes
// the divide by SAMPLE_COUNT (a reciprocal multiply) and then walks the
// voltage profile one entry per cycle, for up to the number of active profile
// entries plus one, before its finish and emit steps.
// one item is worked on at a time: in_stall is high from accept until the
// sequencer is back at its idle step. the result sits in an output register;
// when the receiver stalls it holds its beat and the sequencer waits at its
// emit step. reset is synchronous: it clears the gauge state, the config
// registers go to 1000 ms and 100 mV, and no beat is taken while rst is high.
module battery_level_gauge #(
  parameter int SAMPLE_COUNT    = 100,
  parameter int PROFILE_ENTRIES = 101
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  blg_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output blg_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [blg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blg_pkg::*;

  uop_t   uop;
  flags_t flags;

  blg_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uop   (uop)
  );

  blg_dp #(
    .SAMPLE_COUNT    (SAMPLE_COUNT),
    .PROFILE_ENTRIES (PROFILE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uop       (uop),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: rtl/blg_checker.sv
// battery level gauge port checker and its bind to the top level.
// depends on blg_pkg and battery_level_gauge.
module blg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input blg_pkg::out_t                  out_data
);
  import blg_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back to back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.percentage <= 7'd100)
    else $error("percentage above 100");

  // a measurement is never due while charging
  a_due_not_charging: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.charging && out_data.measure_due))
    else $error("measure due while charging");

endmodule

bind battery_level_gauge blg_checker u_blg_checker (.*);
